>>> rtl/isbn13_string_validator_macros.svh
// assertion macros for the isbn-13 text validator checker
`ifndef ISBN13_STRING_VALIDATOR_MACROS_SVH
`define ISBN13_STRING_VALIDATOR_MACROS_SVH

// concurrent check on the rising edge of clk, off while in reset
`define ISBN13_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check on the rising edge of clk, live during reset too
`define ISBN13_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/isbn13_pkg.sv
// shared types, constants and functions of the isbn-13 text validator
package isbn13_pkg;

  localparam int TEXT_LEN      = 22;
  localparam int POS_MAX       = 31;
  localparam int LEAD_LEN      = 7;
  localparam int GROUP_POS_MAX = 14;
  localparam int GROUP_LEN_MAX = 7;
  localparam int DIGIT_TOTAL   = 13;
  localparam int DIGIT_CNT_MAX = 15;

  localparam logic [16:0] GROUP_SAT = 17'd100000;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DASH = 8'h2d;
  localparam logic [7:0] CHAR_8    = 8'h38;
  localparam logic [7:0] CHAR_9    = 8'h39;

  // one character word
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } word_t;

  // result handed from the checking stage to the result register
  typedef struct packed {
    logic load;
    logic valid_res;
  } res_t;

  // running state of one text
  typedef struct packed {
    logic [4:0]  pos;
    logic        fmt_ok;
    logic        grp_open;
    logic [16:0] grp_val;
    logic [2:0]  grp_len;
    logic [3:0]  dig_cnt;
    logic [3:0]  wsum;
    logic [3:0]  chk_dig;
  } state_t;

  localparam state_t ST_RESET = '{
    pos:      5'd0,
    fmt_ok:   1'b1,
    grp_open: 1'b0,
    grp_val:  17'd0,
    grp_len:  3'd0,
    dig_cnt:  4'd0,
    wsum:     4'd0,
    chk_dig:  4'd0
  };

  // expected characters of "ISBN 97"
  function automatic logic [7:0] lead_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h49;
      3'd1:    c = 8'h53;
      3'd2:    c = 8'h42;
      3'd3:    c = 8'h4e;
      3'd4:    c = 8'h20;
      3'd5:    c = 8'h39;
      3'd6:    c = 8'h37;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // registration group ranges
  function automatic logic group_allowed(input logic [16:0] v);
    logic a;
    a = (v <= 17'd5) || (v == 17'd7)
        || (v >= 17'd80    && v <= 17'd94)
        || (v >= 17'd600   && v <= 17'd649)
        || (v >= 17'd950   && v <= 17'd989)
        || (v >= 17'd9900  && v <= 17'd9989)
        || (v >= 17'd99900 && v <= 17'd99999);
    return a;
  endfunction

endpackage

>>> rtl/isbn13_if.sv
// character and result channel interfaces
interface isbn13_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface isbn13_res_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink   (input valid, input valid_res, output ready);
endinterface

>>> rtl/isbn13_string_validator.sv
// top level of the isbn-13 text validator
//
//  channel   | dir | fields           | handshake
//  ----------+-----+------------------+------------------
//  in_chan   | in  | ch[7:0], last    | valid / ready
//  out_chan  | out | valid_res        | valid / ready
//
// one character word is taken per cycle unless a last word waits on a stalled result;
// the verdict of a text is loaded into the result register as its last word leaves the input register.
// the path from input register through the state update to the result
// register is combinational, so without a stalled result the sustained rate is one word per cycle.
// synchronous active-low reset clears the running state and both valid flags.
// a stalled result only holds back a last word; other words keep flowing.
module isbn13_string_validator (
  input  logic          clk,
  input  logic          rst_n,
  isbn13_char_if.sink   in_chan,
  isbn13_res_if.source  out_chan
);

  logic              adv;
  logic              a_valid;
  logic              out_free;
  isbn13_pkg::word_t a_word;
  isbn13_pkg::res_t  res;

  isbn13_in_reg u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .adv     (adv),
    .a_valid (a_valid),
    .a_word  (a_word)
  );

  isbn13_check u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .a_valid  (a_valid),
    .a_word   (a_word),
    .out_free (out_free),
    .adv      (adv),
    .res      (res)
  );

  isbn13_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .out_free (out_free),
    .out_chan (out_chan)
  );

endmodule

>>> rtl/isbn13_in_reg.sv
// input register holding one character word
module isbn13_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  isbn13_char_if.sink         in_chan,
  input  logic                adv,
  output logic                a_valid,
  output isbn13_pkg::word_t   a_word
);

  logic              a_valid_r, a_valid_nxt;
  isbn13_pkg::word_t a_word_r;
  logic              take;

  assign in_chan.ready = !a_valid_r || adv;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    if (take) begin
      a_valid_nxt = 1'b1;
    end else if (adv) begin
      a_valid_nxt = 1'b0;
    end else begin
      a_valid_nxt = a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_word_r.ch   <= in_chan.ch;
      a_word_r.last <= in_chan.last;
    end
  end

  assign a_valid = a_valid_r;
  assign a_word  = a_word_r;

endmodule

>>> rtl/isbn13_check.sv
// per-character format and check-digit update, verdict on the last word
module isbn13_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               a_valid,
  input  isbn13_pkg::word_t  a_word,
  input  logic               out_free,
  output logic               adv,
  output isbn13_pkg::res_t   res
);

  isbn13_pkg::state_t st_r, st_nxt, s_upd;
  logic               is_dig;
  logic [3:0]         d;
  logic [20:0]        gv_x10;
  logic [5:0]         acc;
  logic [3:0]         chk;
  logic               ok;

  // reduce a value below 40 modulo 10
  function automatic logic [3:0] mod10_small(input logic [5:0] v);
    logic [5:0] r;
    if (v >= 6'd30) begin
      r = v - 6'd30;
    end else if (v >= 6'd20) begin
      r = v - 6'd20;
    end else if (v >= 6'd10) begin
      r = v - 6'd10;
    end else begin
      r = v;
    end
    return r[3:0];
  endfunction

  assign adv = a_valid && (!a_word.last || out_free);

  always_comb begin
    s_upd  = st_r;
    is_dig = (a_word.ch >= isbn13_pkg::CHAR_ZERO) && (a_word.ch <= isbn13_pkg::CHAR_NINE);
    d      = is_dig ? 4'(a_word.ch - isbn13_pkg::CHAR_ZERO) : 4'd0;
    gv_x10 = {1'b0, st_r.grp_val, 3'b000} + {3'b000, st_r.grp_val, 1'b0} + {17'd0, d};

    // fixed lead text, prefix digit 8 or 9, first dash and group field
    if (st_r.pos < 5'(isbn13_pkg::LEAD_LEN)) begin
      if (a_word.ch != isbn13_pkg::lead_char(st_r.pos[2:0])) begin
        s_upd.fmt_ok = 1'b0;
      end
    end else if (st_r.pos == 5'(isbn13_pkg::LEAD_LEN)) begin
      if (a_word.ch != isbn13_pkg::CHAR_8 && a_word.ch != isbn13_pkg::CHAR_9) begin
        s_upd.fmt_ok = 1'b0;
      end
    end else if (st_r.pos == 5'(isbn13_pkg::LEAD_LEN + 1)) begin
      if (a_word.ch != isbn13_pkg::CHAR_DASH) begin
        s_upd.fmt_ok = 1'b0;
      end
      s_upd.grp_open = 1'b1;
    end else if (st_r.grp_open) begin
      if (a_word.ch == isbn13_pkg::CHAR_DASH) begin
        s_upd.grp_open = 1'b0;
        if (st_r.grp_len == 3'd0 || !isbn13_pkg::group_allowed(st_r.grp_val)) begin
          s_upd.fmt_ok = 1'b0;
        end
      end else if (!is_dig || st_r.pos > 5'(isbn13_pkg::GROUP_POS_MAX)) begin
        s_upd.fmt_ok   = 1'b0;
        s_upd.grp_open = 1'b0;
        s_upd.grp_len  = 3'd0;
      end else begin
        if (gv_x10 > {4'd0, isbn13_pkg::GROUP_SAT}) begin
          s_upd.grp_val = isbn13_pkg::GROUP_SAT;
        end else begin
          s_upd.grp_val = gv_x10[16:0];
        end
        if (st_r.grp_len < 3'(isbn13_pkg::GROUP_LEN_MAX)) begin
          s_upd.grp_len = st_r.grp_len + 3'd1;
        end
      end
    end

    // weighted sum of all digits but the latest
    if (st_r.dig_cnt[0]) begin
      acc = {2'b00, st_r.chk_dig} + {2'b00, st_r.wsum};
    end else begin
      acc = {2'b00, st_r.chk_dig} + {1'b0, st_r.chk_dig, 1'b0} + {2'b00, st_r.wsum};
    end
    if (is_dig) begin
      if (st_r.dig_cnt != 4'd0) begin
        s_upd.wsum = mod10_small(acc);
      end
      s_upd.chk_dig = d;
      if (st_r.dig_cnt < 4'(isbn13_pkg::DIGIT_CNT_MAX)) begin
        s_upd.dig_cnt = st_r.dig_cnt + 4'd1;
      end
    end

    if (st_r.pos < 5'(isbn13_pkg::POS_MAX)) begin
      s_upd.pos = st_r.pos + 5'd1;
    end

    chk = (s_upd.wsum == 4'd0) ? 4'd0 : 4'd10 - s_upd.wsum;
    ok  = s_upd.fmt_ok
          && (st_r.pos == 5'(isbn13_pkg::TEXT_LEN - 1))
          && !s_upd.grp_open
          && (s_upd.grp_len != 3'd0)
          && (s_upd.dig_cnt == 4'(isbn13_pkg::DIGIT_TOTAL))
          && (chk == s_upd.chk_dig);

    if (adv) begin
      st_nxt = a_word.last ? isbn13_pkg::ST_RESET : s_upd;
    end else begin
      st_nxt = st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= isbn13_pkg::ST_RESET;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign res = '{load: adv && a_word.last, valid_res: ok};

endmodule

>>> rtl/isbn13_out_reg.sv
// result register driving the result channel
module isbn13_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  isbn13_pkg::res_t  res,
  output logic              out_free,
  isbn13_res_if.source      out_chan
);

  logic out_valid_r, out_valid_nxt;
  logic valid_res_r;

  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    if (res.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      valid_res_r <= res.valid_res;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.valid_res = valid_res_r;

endmodule

>>> rtl/isbn13_checker.sv
// port-level assertions for the isbn-13 text validator, bound to the top level
`include "isbn13_string_validator_macros.svh"

module isbn13_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic valid_res
);

  // a held result stays offered
  `ISBN13_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result word dropped")

  // a held result keeps its value
  `ISBN13_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(valid_res), "result word changed")

  // input only stalls behind a blocked result
  `ISBN13_ASSERT(a_stall_cause, !in_ready |-> out_valid && !out_ready, "input stalled without cause")

  // no result straight after reset
  `ISBN13_ASSERT_ALWAYS(a_reset_clear, $past(!rst_n) |-> !out_valid, "result valid after reset")

endmodule

bind isbn13_string_validator isbn13_checker u_isbn13_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .valid_res (out_chan.valid_res)
);
